/* hdl/bpa_pkg.sv */
`default_nettype none
package bpa_pkg;

  // width of exact address sums: base + offset + alignment slack
  localparam int SUM_W = 34;

  // field widths
  localparam int FIELD_W  = 32;
  localparam int ACTION_W = 2;
  localparam int CFG_IDX_W = 1;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC_ALL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR     = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 1'd1;

  // request into the serial remainder unit
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  // response from the serial remainder unit
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

/* hdl/bpa_div.sv */
`default_nettype none
// radix-2 restoring remainder, one dividend bit shifted in per cycle
module bpa_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bpa_pkg::div_req_t req,
  output bpa_pkg::div_rsp_t      rsp
);

  localparam int W = bpa_pkg::SUM_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     dvd_r, dvd_nxt;
  logic [W-1:0]     dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W-1:0]     rem_sh;

  // load on start, else one restoring step while busy
  always_comb begin
    rem_sh   = {rem_r[W-2:0], dvd_r[W-1]};
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      cnt_nxt  = CNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = (rem_sh >= dvs_r) ? rem_sh - dvs_r : rem_sh;
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

/* hdl/bump_allocator_aligned_top.sv */
// path, input beat to out_tvalid: allocate goes through DIV1, ALN, AVL, DEC, COMMIT, FIN and
// OUT, allocate-all also through DIV2 after DEC, clear or unknown action through FIN and OUT;
// an allocation refused at the room check skips COMMIT. One item at a time: in_tready rises
// as the result loads, so items follow one another while out_tready keeps up; the bit-serial
// remainder unit sets the pace, run once for the alignment, again for the allocate-all multiple
// reset (rst_n low, synchronous) clears the used offset, both heap registers and the output beat
`default_nettype none
module bump_allocator_aligned_top #(
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpa_pkg::FIELD_W-1:0]    cfg_wdata,
  // request stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [63:0]                    in_tdata,  // req_size[31:0], alignment[63:32]
  input  wire logic [bpa_pkg::ACTION_W-1:0]   in_tuser,  // action[1:0]
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [95:0]                         out_tdata, // block_address[31:0],
                                                         // granted_size[63:32],
                                                         // bytes_remaining[95:64]
  output logic                                out_tuser  // ok[0]
);

  localparam int W  = bpa_pkg::SUM_W;
  localparam int FW = bpa_pkg::FIELD_W;
  localparam logic [W-1:0] LIMIT = (ADDR_WIDTH >= W) ? {W{1'b1}}
                                   : ({{(W-1){1'b0}}, 1'b1} << ADDR_WIDTH);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV1   = 4'd1;
  localparam logic [3:0] S_ALN    = 4'd2;
  localparam logic [3:0] S_AVL    = 4'd3;
  localparam logic [3:0] S_DEC    = 4'd4;
  localparam logic [3:0] S_DIV2   = 4'd5;
  localparam logic [3:0] S_COMMIT = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [FW-1:0] base_r, size_r, used_r;
  logic [bpa_pkg::ACTION_W-1:0] act_r;
  logic [FW-1:0] req_r;
  logic [W-1:0]  aln_r;
  logic [W-1:0]  cur_r, end_r, start_r, avail_r, grant_r;
  logic          start_ok_r;
  logic [FW-1:0] addr_r;
  logic          ok_r;

  logic          out_valid_r;
  logic          out_ok_r;
  logic [FW-1:0] out_addr_r, out_grant_r, out_left_r;

  logic          in_acc;
  logic [W-1:0]  end_raw, end_cap, cur_now, aln_in, mult;
  logic          out_free;

  bpa_pkg::div_req_t dreq;
  bpa_pkg::div_rsp_t drsp;

  bpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // window end and current address from the registers; alignment and multiple, zero read as one
  always_comb begin
    end_raw = W'(base_r) + W'(size_r);
    end_cap = (end_raw > LIMIT) ? LIMIT : end_raw;
    cur_now = W'(base_r) + W'(used_r);
    aln_in  = (in_tdata[63:32] == '0) ? W'(1) : W'(in_tdata[63:32]);
    mult    = (req_r == '0) ? W'(1) : W'(req_r);
  end

  // remainder unit requests
  always_comb begin
    dreq = '0;
    if (in_acc && (in_tuser == bpa_pkg::ACT_ALLOC ||
                   in_tuser == bpa_pkg::ACT_ALLOC_ALL)) begin
      dreq.start    = 1'b1;
      dreq.dividend = cur_now;
      dreq.divisor  = aln_in;
    end else if (state_r == S_DEC && act_r == bpa_pkg::ACT_ALLOC_ALL && avail_r >= mult) begin
      dreq.start    = 1'b1;
      dreq.dividend = avail_r;
      dreq.divisor  = mult;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == bpa_pkg::ACT_ALLOC || in_tuser == bpa_pkg::ACT_ALLOC_ALL) begin
            state_nxt = S_DIV1;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DIV1:   if (drsp.done) state_nxt = S_ALN;
      S_ALN:    state_nxt = S_AVL;
      S_AVL:    state_nxt = S_DEC;
      S_DEC: begin
        if (act_r == bpa_pkg::ACT_ALLOC) begin
          state_nxt = (W'(req_r) <= avail_r && start_ok_r) ? S_COMMIT : S_FIN;
        end else begin
          state_nxt = (avail_r >= mult) ? S_DIV2 : S_FIN;
        end
      end
      S_DIV2:   if (drsp.done) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_FIN;
      S_FIN:    state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state, heap registers and used offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r  <= '0;
      size_r  <= '0;
      used_r  <= '0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bpa_pkg::REG_HEAP_BASE: base_r <= cfg_wdata;
          bpa_pkg::REG_HEAP_SIZE: size_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        ok_r <= (in_tuser == bpa_pkg::ACT_CLEAR);
        if (in_tuser == bpa_pkg::ACT_CLEAR) begin
          used_r <= '0;
        end
      end
      if (state_r == S_COMMIT) begin
        ok_r   <= 1'b1;
        used_r <= start_r[FW-1:0] + grant_r[FW-1:0] - base_r;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= in_tuser;
      req_r   <= in_tdata[31:0];
      aln_r   <= aln_in;
      cur_r   <= cur_now;
      end_r   <= end_cap;
      addr_r  <= '0;
      grant_r <= '0;
    end
    // round the current address up to the alignment
    if (state_r == S_ALN) begin
      start_r <= (drsp.rem != '0) ? cur_r + aln_r - drsp.rem : cur_r;
    end
    // room left from the aligned start
    if (state_r == S_AVL) begin
      avail_r    <= (start_r < end_r) ? end_r - start_r : '0;
      start_ok_r <= (start_r <= end_r);
    end
    if (state_r == S_DEC && act_r == bpa_pkg::ACT_ALLOC) begin
      grant_r <= W'(req_r);
    end
    if (state_r == S_DIV2 && drsp.done) begin
      grant_r <= avail_r - drsp.rem;
    end
    if (state_r == S_COMMIT) begin
      addr_r <= start_r[FW-1:0];
    end
    if (state_r == S_FIN) begin
      cur_r <= cur_now;
      if (!ok_r) begin
        grant_r <= '0;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_ok_r    <= ok_r;
      out_addr_r  <= addr_r;
      out_grant_r <= grant_r[FW-1:0];
      out_left_r  <= (cur_r < end_r) ? FW'(end_r - cur_r) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {out_left_r, out_grant_r, out_addr_r};

endmodule
`default_nettype wire
